// ===== src/bpc_pkg.sv =====
package bpc_pkg;

  // Default width of the timestamp arithmetic
  localparam int unsigned TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned NOW_W  = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned KIND_W = 2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ENABLED    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BOUND_KIND = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_LONG_THR   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_DOUBLE_GAP = 3'd5;

  // Detected gesture codes
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd3;

  // Register reset values
  localparam logic             RST_ENABLED    = 1'b1;
  localparam logic             RST_PRESS_LOW  = 1'b1;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd20;
  localparam logic [1:0]       RST_BOUND_KIND = 2'd0;
  localparam logic [CFG_W-1:0] RST_LONG_THR   = 16'd600;
  localparam logic [CFG_W-1:0] RST_DOUBLE_GAP = 16'd250;

  typedef struct packed {
    logic             enabled;
    logic             press_low;
    logic [CFG_W-1:0] debounce_time;
    logic [1:0]       bound_kind;
    logic [CFG_W-1:0] long_threshold;
    logic [CFG_W-1:0] double_gap;
  } bpc_cfg_t;

  typedef struct packed {
    logic              fire;
    logic [KIND_W-1:0] detected_kind;
    logic              pressed;
  } bpc_res_t;

endpackage

// ===== src/bpc_core.sv =====
module bpc_core #(
  parameter int unsigned TIME_BITS = bpc_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpc_pkg::bpc_cfg_t            cfg,
  input  logic                         accept,
  input  logic                         pin_level,
  input  logic [bpc_pkg::NOW_W-1:0]    now_ms,
  output bpc_pkg::bpc_res_t            res
);

  logic                 raw_prev_r,   raw_prev_nxt;
  logic                 deb_press_r,  deb_press_nxt;
  logic [TIME_BITS-1:0] last_edge_r,  last_edge_nxt;
  logic [TIME_BITS-1:0] press_start_r, press_start_nxt;
  logic [TIME_BITS-1:0] last_rel_r,   last_rel_nxt;
  logic                 long_done_r,  long_done_nxt;
  logic                 dbl_armed_r,  dbl_armed_nxt;

  logic                         raw;
  logic [TIME_BITS-1:0]         now_t;
  logic [TIME_BITS-1:0]         stable_age;
  logic [TIME_BITS-1:0]         hold_age;
  logic [TIME_BITS-1:0]         rel_age;
  logic [TIME_BITS-1:0]         deb_t;
  logic [TIME_BITS-1:0]         long_t;
  logic [TIME_BITS-1:0]         gap_t;
  logic                         is_long;
  logic [bpc_pkg::KIND_W-1:0]   kind;

  assign raw    = cfg.press_low ? ~pin_level : pin_level;
  assign now_t  = now_ms[TIME_BITS-1:0];
  assign deb_t  = TIME_BITS'(cfg.debounce_time);
  assign long_t = TIME_BITS'(cfg.long_threshold);
  assign gap_t  = TIME_BITS'(cfg.double_gap);

  // Debounce, then classify the gesture for this word
  always_comb begin
    raw_prev_nxt    = raw_prev_r;
    deb_press_nxt   = deb_press_r;
    last_edge_nxt   = last_edge_r;
    press_start_nxt = press_start_r;
    last_rel_nxt    = last_rel_r;
    long_done_nxt   = long_done_r;
    dbl_armed_nxt   = dbl_armed_r;
    kind            = bpc_pkg::KIND_NONE;
    hold_age        = now_t - press_start_r;
    is_long         = (hold_age >= long_t);
    stable_age      = '0;
    rel_age         = '0;
    if (cfg.enabled) begin
      // restart the stability window on a raw level change
      if (raw != raw_prev_r) begin
        raw_prev_nxt  = raw;
        last_edge_nxt = now_t;
      end
      stable_age = now_t - last_edge_nxt;
      if (stable_age >= deb_t) begin
        if (raw && !deb_press_r) begin
          deb_press_nxt   = 1'b1;
          press_start_nxt = now_t;
          long_done_nxt   = 1'b0;
        end else if (!raw && deb_press_r) begin
          deb_press_nxt = 1'b0;
          if (!is_long && dbl_armed_r && ((now_t - last_rel_r) <= gap_t)) begin
            kind          = bpc_pkg::KIND_DOUBLE;
            dbl_armed_nxt = 1'b0;
          end else if (!is_long) begin
            dbl_armed_nxt = 1'b1;
          end
          last_rel_nxt = now_t;
        end else if (raw && deb_press_r && !long_done_r) begin
          if (is_long) begin
            kind          = bpc_pkg::KIND_LONG;
            long_done_nxt = 1'b1;
            dbl_armed_nxt = 1'b0;
          end
        end
        // lone release whose gap has expired
        rel_age = now_t - last_rel_nxt;
        if (dbl_armed_nxt && !deb_press_nxt && (rel_age > gap_t)) begin
          kind          = bpc_pkg::KIND_SHORT;
          dbl_armed_nxt = 1'b0;
        end
      end
    end
  end

  assign res.detected_kind = kind;
  assign res.pressed       = deb_press_nxt;
  assign res.fire          = (kind != bpc_pkg::KIND_NONE) &&
                             (kind == bpc_pkg::KIND_W'(cfg.bound_kind + 2'd1));

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r  <= 1'b0;
      deb_press_r <= 1'b0;
      long_done_r <= 1'b0;
      dbl_armed_r <= 1'b0;
    end else if (accept) begin
      raw_prev_r  <= raw_prev_nxt;
      deb_press_r <= deb_press_nxt;
      long_done_r <= long_done_nxt;
      dbl_armed_r <= dbl_armed_nxt;
    end
  end

  // Timestamps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r   <= '0;
      press_start_r <= '0;
      last_rel_r    <= '0;
    end else if (accept) begin
      last_edge_r   <= last_edge_nxt;
      press_start_r <= press_start_nxt;
      last_rel_r    <= last_rel_nxt;
    end
  end

  a_long_while_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.detected_kind == bpc_pkg::KIND_LONG) |=> deb_press_r)
    else $error("long press reported without a held button");

  a_tap_when_released: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (res.detected_kind == bpc_pkg::KIND_SHORT ||
                res.detected_kind == bpc_pkg::KIND_DOUBLE)) |=> !deb_press_r && !dbl_armed_r)
    else $error("tap reported while pressed or still armed");

  a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg.enabled) |=> $stable(deb_press_r) && $stable(dbl_armed_r))
    else $error("state changed while disabled");

endmodule

// ===== src/button_press_classifier.sv =====
// Channel   | Direction | Word
// ----------+-----------+------------------------------------------------
// in_       | input     | pin_level, now_ms (one poll tick)
// out_      | output    | fire, detected_kind, pressed (one per tick)
// cfg_      | input     | register index, write data (no read-back)
//
// One tick enters every cycle while in_stall is low; its result is registered in
// the output register (the skid entry under out_stall). The debounce and classify
// logic is a single pass of subtract-compare steps between the state registers and
// the output register. A two-entry output buffer (output register plus skid) takes
// words while out_stall is high; in_stall rises only when both entries are full.
// Reset (rst_n low, synchronous) clears gesture state and loads register defaults.
module button_press_classifier #(
  parameter int unsigned TIME_BITS = bpc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bpc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  input  logic [bpc_pkg::NOW_W-1:0]     in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_fire,
  output logic [bpc_pkg::KIND_W-1:0]    out_detected_kind,
  output logic                          out_pressed
);

  bpc_pkg::bpc_cfg_t cfg_r;
  bpc_pkg::bpc_res_t res;
  bpc_pkg::bpc_res_t out_r,  out_nxt;
  bpc_pkg::bpc_res_t skid_r, skid_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic              accept;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled        <= bpc_pkg::RST_ENABLED;
      cfg_r.press_low      <= bpc_pkg::RST_PRESS_LOW;
      cfg_r.debounce_time  <= bpc_pkg::RST_DEBOUNCE;
      cfg_r.bound_kind     <= bpc_pkg::RST_BOUND_KIND;
      cfg_r.long_threshold <= bpc_pkg::RST_LONG_THR;
      cfg_r.double_gap     <= bpc_pkg::RST_DOUBLE_GAP;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpc_pkg::CFG_ENABLED:    cfg_r.enabled        <= cfg_data[0];
        bpc_pkg::CFG_PRESS_LOW:  cfg_r.press_low      <= cfg_data[0];
        bpc_pkg::CFG_DEBOUNCE:   cfg_r.debounce_time  <= cfg_data;
        bpc_pkg::CFG_BOUND_KIND: cfg_r.bound_kind     <= cfg_data[1:0];
        bpc_pkg::CFG_LONG_THR:   cfg_r.long_threshold <= cfg_data;
        bpc_pkg::CFG_DOUBLE_GAP: cfg_r.double_gap     <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .pin_level (in_pin_level),
    .now_ms    (in_now_ms),
    .res       (res)
  );

  // Advance the output register and the skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && out_stall) begin
      if (accept) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (skid_valid_r) begin
      out_nxt        = skid_r;
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end else begin
      out_nxt       = res;
      out_valid_nxt = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_fire          = out_r.fire;
  assign out_detected_kind = out_r.detected_kind;
  assign out_pressed       = out_r.pressed;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full with output register empty");

  a_stalled_word_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid_r && out_stall) |=> skid_valid_r && out_valid_r)
    else $error("accepted word lost under output stall");

  a_fire_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.fire) |-> (out_r.detected_kind != bpc_pkg::KIND_NONE))
    else $error("fire without a detected gesture");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r)
    else $error("skid entry not drained when output moved");

endmodule
